### hw/rtl/lcd_seq_pkg.sv
// Shared types and constants of the character LCD write sequencer.
`default_nettype none

package lcd_seq_pkg;

    localparam int OPCODE_W  = 3;
    localparam int BYTE_W    = 8;
    localparam int COLUMN_W  = 6;
    localparam int OFFSET_W  = 7;
    localparam int NUM_W     = 32;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int BIT_CNT_W = 6;
    localparam int DIG_CNT_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_COMMAND = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DATA    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CURSOR  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_INIT    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PRINT   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET = 1'd1;

    localparam logic [OFFSET_W-1:0] ROW_OFFSET_RESET = 7'd64;

    // display command and character bytes
    localparam logic [BYTE_W-1:0] LCD_FUNC_SET_8BIT = 8'h38;
    localparam logic [BYTE_W-1:0] LCD_FUNC_SET_4BIT = 8'h28;
    localparam logic [BYTE_W-1:0] LCD_DISPLAY_ON    = 8'h0C;
    localparam logic [BYTE_W-1:0] LCD_CLEAR         = 8'h01;
    localparam logic [BYTE_W-1:0] LCD_DDRAM_FLAG    = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_MINUS       = 8'h2D;
    localparam logic [3:0]        ASCII_DIGIT_HI    = 4'h3;

    // source of the byte currently being strobed
    typedef enum logic [2:0] {
        SEL_REQ,
        SEL_CURSOR,
        SEL_FUNC_SET,
        SEL_DISP_ON,
        SEL_CLEAR,
        SEL_MINUS,
        SEL_DIGIT
    } byte_sel_t;

    typedef struct packed {
        logic      load;
        logic      conv_step;
        logic      digit_shift;
        logic      strobe_load;
        byte_sel_t sel;
        logic      nibble_lo;
        logic      rs;
        logic      last;
    } lcd_cmd_t;

    typedef struct packed {
        logic out_free;
        logic four_bit;
        logic conv_last;
        logic top_zero;
        logic digits_one;
    } lcd_sts_t;

endpackage

`default_nettype wire

### hw/rtl/lcd_seq_req_if.sv
// Request channel: one word per sequencer request.
`default_nettype none

interface lcd_seq_req_if;
    logic                              valid;
    logic                              ready;
    logic [lcd_seq_pkg::OPCODE_W-1:0]  opcode;
    logic [lcd_seq_pkg::BYTE_W-1:0]    byte_value;
    logic                              row;
    logic [lcd_seq_pkg::COLUMN_W-1:0]  column;
    logic signed [lcd_seq_pkg::NUM_W-1:0] number;

    modport source (output valid, opcode, byte_value, row, column, number, input ready);
    modport sink   (input valid, opcode, byte_value, row, column, number, output ready);
endinterface

`default_nettype wire

### hw/rtl/lcd_seq_strobe_if.sv
// Strobe channel: one word per enable strobe on the display bus.
`default_nettype none

interface lcd_seq_strobe_if;
    logic                           valid;
    logic                           ready;
    logic                           reg_select;
    logic                           read_write;
    logic [lcd_seq_pkg::BYTE_W-1:0] bus_value;
    logic                           last;

    modport source (output valid, reg_select, read_write, bus_value, last, input ready);
    modport sink   (input valid, reg_select, read_write, bus_value, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/lcd_seq_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface lcd_seq_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lcd_seq_pkg::CFG_IDX_W-1:0] index;
    logic [lcd_seq_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/lcd_seq_ctrl.sv
// Controller state machine of the LCD write sequencer.
`default_nettype none

module lcd_seq_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    input  wire logic [lcd_seq_pkg::OPCODE_W-1:0] req_opcode,
    input  wire logic                             req_negative,
    output logic                                  req_ready,
    input  wire lcd_seq_pkg::lcd_sts_t            sts,
    output lcd_seq_pkg::lcd_cmd_t                 cmd
);
    import lcd_seq_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_BYTE, ST_CONV, ST_SKIP} state_t;

    state_t    state_reg, state_next;
    byte_sel_t sel_reg, sel_next;
    logic      rs_reg, rs_next;
    logic      nib_reg, nib_next;

    logic req_fire;
    logic final_byte;
    logic byte_done;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        final_byte = (sel_reg inside {SEL_REQ, SEL_CURSOR, SEL_CLEAR})
                     || (sel_reg == SEL_DIGIT && sts.digits_one);
        byte_done  = !sts.four_bit || nib_reg;

        cmd             = '0;
        cmd.load        = req_fire;
        cmd.sel         = sel_reg;
        cmd.nibble_lo   = nib_reg;
        cmd.rs          = rs_reg;
        cmd.last        = final_byte && byte_done;

        state_next = state_reg;
        sel_next   = sel_reg;
        rs_next    = rs_reg;
        nib_next   = nib_reg;

        case (state_reg)
            ST_IDLE:
            begin
                nib_next = 1'b0;
                if (req_fire)
                begin
                    case (req_opcode)
                        OP_COMMAND:
                        begin
                            state_next = ST_BYTE;
                            sel_next   = SEL_REQ;
                            rs_next    = 1'b0;
                        end
                        OP_DATA:
                        begin
                            state_next = ST_BYTE;
                            sel_next   = SEL_REQ;
                            rs_next    = 1'b1;
                        end
                        OP_CURSOR:
                        begin
                            state_next = ST_BYTE;
                            sel_next   = SEL_CURSOR;
                            rs_next    = 1'b0;
                        end
                        OP_INIT:
                        begin
                            state_next = ST_BYTE;
                            sel_next   = SEL_FUNC_SET;
                            rs_next    = 1'b0;
                        end
                        OP_PRINT:
                        begin
                            rs_next = 1'b1;
                            if (req_negative)
                            begin
                                state_next = ST_BYTE;
                                sel_next   = SEL_MINUS;
                            end
                            else
                            begin
                                state_next = ST_CONV;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;   // unused opcode: nothing strobed
                        end
                    endcase
                end
            end
            ST_BYTE:
            begin
                if (sts.out_free)
                begin
                    cmd.strobe_load = 1'b1;
                    if (!byte_done)
                    begin
                        nib_next = 1'b1;
                    end
                    else
                    begin
                        nib_next = 1'b0;
                        if (final_byte)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            case (sel_reg)
                                SEL_FUNC_SET: sel_next = SEL_DISP_ON;
                                SEL_DISP_ON:  sel_next = SEL_CLEAR;
                                SEL_MINUS:    state_next = ST_CONV;
                                SEL_DIGIT:    cmd.digit_shift = 1'b1;
                                default:      state_next = ST_IDLE;
                            endcase
                        end
                    end
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (sts.conv_last)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, always keeping the units digit
                if (sts.top_zero && !sts.digits_one)
                begin
                    cmd.digit_shift = 1'b1;
                end
                else
                begin
                    state_next = ST_BYTE;
                    sel_next   = SEL_DIGIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= SEL_REQ;
            rs_reg    <= 1'b0;
            nib_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            rs_reg    <= rs_next;
            nib_reg   <= nib_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lcd_seq_dp.sv
// Datapath of the LCD write sequencer: config, operands, BCD converter, strobe register.
`default_nettype none

module lcd_seq_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lcd_seq_pkg::lcd_cmd_t               cmd,
    output lcd_seq_pkg::lcd_sts_t                    sts,
    input  wire logic                                cfg_we,
    input  wire logic [lcd_seq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lcd_seq_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  wire logic [lcd_seq_pkg::BYTE_W-1:0]      req_byte_value,
    input  wire logic                                req_row,
    input  wire logic [lcd_seq_pkg::COLUMN_W-1:0]    req_column,
    input  wire logic signed [lcd_seq_pkg::NUM_W-1:0] req_number,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic                                     out_reg_select,
    output logic [lcd_seq_pkg::BYTE_W-1:0]           out_bus_value,
    output logic                                     out_last
);
    import lcd_seq_pkg::*;

    logic                 four_bit_reg;
    logic [OFFSET_W-1:0]  row_offset_reg;

    logic [BYTE_W-1:0]    byte_reg;
    logic [BYTE_W-1:0]    cursor_reg, cursor_next;
    logic [NUM_W-1:0]     mag_reg, mag_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [DIG_CNT_W-1:0] dig_cnt_reg;

    logic                 out_valid_reg;
    logic                 rs_reg;
    logic [BYTE_W-1:0]    bus_reg, bus_next;
    logic                 last_reg;
    logic [BYTE_W-1:0]    sel_byte;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg   <= 1'b0;
            row_offset_reg <= ROW_OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FOUR_BIT:   four_bit_reg   <= cfg_data[0];
                CFG_ROW_OFFSET: row_offset_reg <= cfg_data;
                default:        four_bit_reg   <= four_bit_reg;
            endcase
        end
    end

    // shift-and-add-3 step
    always_comb
    begin
        logic [3:0] dig;
        for (int i = 0; i < DIGITS; i++)
        begin
            dig = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
        bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[NUM_W-1]};
        mag_next = {mag_reg[NUM_W-2:0], 1'b0};
    end

    always_comb
    begin
        cursor_next = {2'b00, req_column};
        if (req_row)
        begin
            cursor_next = cursor_next + {1'b0, row_offset_reg};
        end
        cursor_next = cursor_next | LCD_DDRAM_FLAG;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg    <= req_byte_value;
            cursor_reg  <= cursor_next;
            mag_reg     <= req_number[NUM_W-1] ? NUM_W'(0) - NUM_W'(req_number)
                                               : NUM_W'(req_number);
            bcd_reg     <= '0;
            bit_cnt_reg <= BIT_CNT_W'(NUM_W);
            dig_cnt_reg <= DIG_CNT_W'(DIGITS);
        end
        else if (cmd.conv_step)
        begin
            mag_reg     <= mag_next;
            bcd_reg     <= bcd_next;
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end
        else if (cmd.digit_shift)
        begin
            bcd_reg     <= {bcd_reg[BCD_W-5:0], 4'h0};
            dig_cnt_reg <= dig_cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_REQ:      sel_byte = byte_reg;
            SEL_CURSOR:   sel_byte = cursor_reg;
            SEL_FUNC_SET: sel_byte = four_bit_reg ? LCD_FUNC_SET_4BIT : LCD_FUNC_SET_8BIT;
            SEL_DISP_ON:  sel_byte = LCD_DISPLAY_ON;
            SEL_CLEAR:    sel_byte = LCD_CLEAR;
            SEL_MINUS:    sel_byte = ASCII_MINUS;
            SEL_DIGIT:    sel_byte = {ASCII_DIGIT_HI, bcd_reg[BCD_W-1 -: 4]};
            default:      sel_byte = byte_reg;
        endcase
        if (!four_bit_reg)
        begin
            bus_next = sel_byte;
        end
        else if (cmd.nibble_lo)
        begin
            bus_next = {sel_byte[3:0], 4'h0};
        end
        else
        begin
            bus_next = {sel_byte[7:4], 4'h0};
        end
    end

    // strobe output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.strobe_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.strobe_load)
        begin
            rs_reg   <= cmd.rs;
            bus_reg  <= bus_next;
            last_reg <= cmd.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_reg_select = rs_reg;
    assign out_bus_value  = bus_reg;
    assign out_last       = last_reg;

    assign sts = '{out_free:   !out_valid_reg || out_ready,
                   four_bit:   four_bit_reg,
                   conv_last:  (bit_cnt_reg == BIT_CNT_W'(1)),
                   top_zero:   (bcd_reg[BCD_W-1 -: 4] == 4'h0),
                   digits_one: (dig_cnt_reg == DIG_CNT_W'(1))};

endmodule

`default_nettype wire

### hw/rtl/char_lcd_write_sequencer_core.sv
// Top level of the character LCD write sequencer.
//
// Usage notes
//  - req: one word per request (command, data, set cursor, initialise, print
//    number). Taken only while the sequencer is idle; opcodes 5..7 are
//    swallowed without any strobe.
//  - strobe: one word per enable strobe (register select, bus value, last).
//    A single output register holds the word; the next strobe is loaded in
//    the cycle the current one is taken, so a free-running receiver sees one
//    word per cycle. When the receiver stalls the sequence simply pauses.
//  - cfg: register writes, always ready, index 0 four-bit mode, 1 row offset.
//  - First strobe: the taken request moves the controller to its byte state,
//    which then loads the strobe output register (number print without a sign:
//    once the conversion has finished). Number print runs the 32-step
//    shift-and-add-3 converter (one bit a cycle), drops leading zeros one digit
//    a cycle and then strobes the digits.
//  - Reset: idle, no strobe pending, eight-bit mode, row offset 64.
`default_nettype none

module char_lcd_write_sequencer_core (
    input  wire logic clk,
    input  wire logic rst_n,
    lcd_seq_req_if.sink      req,
    lcd_seq_strobe_if.source strobe,
    lcd_seq_cfg_if.sink      cfg
);
    import lcd_seq_pkg::*;

    lcd_cmd_t cmd;
    lcd_sts_t sts;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;

    lcd_seq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req.valid),
        .req_opcode   (req.opcode),
        .req_negative (req.number[NUM_W-1]),
        .req_ready    (req.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    lcd_seq_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg.valid && cfg.ready),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .req_byte_value (req.byte_value),
        .req_row        (req.row),
        .req_column     (req.column),
        .req_number     (req.number),
        .out_ready      (strobe.ready),
        .out_valid      (strobe.valid),
        .out_reg_select (strobe.reg_select),
        .out_bus_value  (strobe.bus_value),
        .out_last       (strobe.last)
    );

    // the display bus is only ever written
    assign strobe.read_write = 1'b0;

    // a new strobe never overwrites a word still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.strobe_load |-> sts.out_free)
        else $error("strobe loaded over a pending word");

    // in four-bit mode the low bus lines stay clear
    a_nibble_low_clear: assert property (@(posedge clk) disable iff (!rst_n)
        strobe.valid && sts.four_bit |-> strobe.bus_value[3:0] == 4'h0)
        else $error("low nibble driven in four-bit mode");

    // digit queue never shifted past the units digit
    a_digit_floor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.digit_shift |-> !sts.digits_one)
        else $error("digit shifted past the units digit");

    // an unused opcode produces no strobe
    a_unused_opcode: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.opcode > OP_PRINT |=> !cmd.strobe_load)
        else $error("strobe for an unused opcode");

endmodule

`default_nettype wire

### bench/lcd_strobe_checker.sv
// Strobe checker: predicts the bus strobes of each request and compares them word by word.
`default_nettype none

module lcd_strobe_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    lcd_seq_req_if           req,
    lcd_seq_strobe_if        strobe,
    lcd_seq_cfg_if           cfg,
    output int               fail_count,
    output int               strobes_left,
    output int               strobes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import lcd_seq_pkg::*;

    typedef struct packed {
        logic              reg_select;
        logic              read_write;
        logic [BYTE_W-1:0] bus_value;
        logic              last;
    } strobe_word_t;

    strobe_word_t          pending_strobes[$];
    strobe_word_t          request_strobes[$];
    logic                  four_bit;
    logic [OFFSET_W-1:0]   row_offset;

    // one byte is one strobe, or two nibble strobes on bits 7..4
    function void add_byte(logic rs, logic [BYTE_W-1:0] b);
        strobe_word_t w;
        w = '{reg_select: rs, read_write: 1'b0, bus_value: b, last: 1'b0};
        if (four_bit)
        begin
            w.bus_value = {b[7:4], 4'h0};
            request_strobes.push_back(w);
            w.bus_value = {b[3:0], 4'h0};
        end
        request_strobes.push_back(w);
    endfunction

    function void predict_strobes(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] b, logic r,
                                  logic [COLUMN_W-1:0] col, logic [NUM_W-1:0] num);
        logic [BYTE_W-1:0] addr;
        logic [NUM_W-1:0]  mag;
        logic [3:0]        digit_buf[DIGITS];
        int                n;
        request_strobes.delete();
        case (op)
            OP_COMMAND: add_byte(1'b0, b);
            OP_DATA:    add_byte(1'b1, b);
            OP_CURSOR:
            begin
                addr = {2'b00, col} + (r ? {1'b0, row_offset} : 8'd0);
                add_byte(1'b0, addr | LCD_DDRAM_FLAG);
            end
            OP_INIT:
            begin
                add_byte(1'b0, four_bit ? LCD_FUNC_SET_4BIT : LCD_FUNC_SET_8BIT);
                add_byte(1'b0, LCD_DISPLAY_ON);
                add_byte(1'b0, LCD_CLEAR);
            end
            OP_PRINT:
            begin
                if (num == '0)
                    add_byte(1'b1, {ASCII_DIGIT_HI, 4'd0});
                else
                begin
                    mag = num;
                    if (num[NUM_W-1])
                    begin
                        add_byte(1'b1, ASCII_MINUS);
                        mag = -num;
                    end
                    n = 0;
                    while (mag != '0)
                    begin
                        digit_buf[n] = 4'(mag % 10);
                        mag = mag / 10;
                        n++;
                    end
                    while (n > 0)
                    begin
                        n--;
                        add_byte(1'b1, {ASCII_DIGIT_HI, digit_buf[n]});
                    end
                end
            end
            default: ;
        endcase
        if (request_strobes.size() > 0)
            request_strobes[request_strobes.size()-1].last = 1'b1;
        foreach (request_strobes[i])
            pending_strobes.push_back(request_strobes[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        strobe_word_t want;
        strobe_word_t got;
        if (!rst_n)
        begin
            four_bit     = 1'b0;
            row_offset   = ROW_OFFSET_RESET;
            pending_strobes.delete();
            fail_count   = 0;
            strobes_seen = 0;
        end
        else
        begin
            if (strobe.valid && strobe.ready)
            begin
                got = '{strobe.reg_select, strobe.read_write, strobe.bus_value, strobe.last};
                strobes_seen++;
                if (pending_strobes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected strobe: rs=%0d rw=%0d bus=%02h last=%0d",
                                 $realtime, got.reg_select, got.read_write, got.bus_value,
                                 got.last);
                end
                else
                begin
                    want = pending_strobes.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("[%0t] strobe %0d mismatch: expected rs=%0d rw=%0d bus=%02h last=%0d,",
                                     $realtime, strobes_seen, want.reg_select, want.read_write,
                                     want.bus_value, want.last);
                            $display("    got rs=%0d rw=%0d bus=%02h last=%0d",
                                     got.reg_select, got.read_write, got.bus_value, got.last);
                        end
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FOUR_BIT:   four_bit   = cfg.data[0];
                    CFG_ROW_OFFSET: row_offset = cfg.data;
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                predict_strobes(req.opcode, req.byte_value, req.row, req.column, req.number);
        end
        strobes_left = pending_strobes.size();
    end

endmodule

`default_nettype wire

### bench/tb_char_lcd_write_sequencer_core.sv
// Testbench top: drives requests and register writes, applies back-pressure, gives the verdict.
`default_nettype none

module tb_char_lcd_write_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lcd_seq_pkg::*;

    // opcodes above OP_PRINT are spare and must be swallowed silently
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    int   requests_sent      = 0;
    int   prints_sent        = 0;
    int   spares_sent        = 0;

    int   fail_count;
    int   strobes_left;
    int   strobes_seen;

    lcd_seq_req_if    req_ch ();
    lcd_seq_strobe_if strobe_ch ();
    lcd_seq_cfg_if    cfg_ch ();

    char_lcd_write_sequencer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_ch),
        .strobe (strobe_ch),
        .cfg    (cfg_ch)
    );

    lcd_strobe_checker strobe_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .strobe       (strobe_ch),
        .cfg          (cfg_ch),
        .fail_count   (fail_count),
        .strobes_left (strobes_left),
        .strobes_seen (strobes_seen)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: ready is re-rolled every falling edge; a zero stall rate gives a free sink
    always @(negedge clk)
        strobe_ch.ready = ($urandom_range(99) >= receiver_stall_pct);

    // Inputs change on the falling edge only; every task starts and ends just after one.
    // The word is held until a rising edge sees ready, then the next call may replace it.
    task automatic send_request(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] b, logic r,
                                logic [COLUMN_W-1:0] col, logic [NUM_W-1:0] num);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.opcode     = op;
        req_ch.byte_value = b;
        req_ch.row        = r;
        req_ch.column     = col;
        req_ch.number     = num;
        req_ch.valid      = 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
        requests_sent++;
        if (op == OP_PRINT)
            prints_sent++;
        if (op >= OP_SPARE_LO)
            spares_sent++;
    endtask

    // numbers spread over every digit count, both signs and the range ends
    function automatic logic [NUM_W-1:0] pick_number();
        logic [NUM_W-1:0] v;
        int               k;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $urandom_range(20) - 10;
            2:
            begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'hffff_ffff;
                    default: v = 32'h8000_0001;
                endcase
            end
            3:
            begin
                // just below, at or above a power of ten
                k = $urandom_range(9);
                v = 1;
                repeat (k) v = v * 10;
                v = v - 1 + $urandom_range(2);
                if ($urandom_range(1))
                    v = -v;
            end
            default:
            begin
                k = $urandom_range(1, 9);
                v = 1;
                repeat (k) v = v * 10;
                v = $urandom % v;
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // random requests; spare opcodes are sprinkled in but do not count towards n
    task automatic send_random(int n);
        int                  done;
        logic [OPCODE_W-1:0] op;
        done = 0;
        while (done < n)
        begin
            if ($urandom_range(99) < 6)
                op = OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            else
                op = OPCODE_W'($urandom_range(OP_COMMAND, OP_PRINT));
            send_request(op, BYTE_W'($urandom), 1'($urandom), COLUMN_W'($urandom),
                         pick_number());
            if (op < OP_SPARE_LO)
                done++;
        end
    endtask

    // wait for every expected word, then give a trailing spare opcode time to be swallowed
    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (strobes_left != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    initial
    begin
        req_ch.valid      = 1'b0;
        req_ch.opcode     = OP_COMMAND;
        req_ch.byte_value = '0;
        req_ch.row        = 1'b0;
        req_ch.column     = '0;
        req_ch.number     = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_FOUR_BIT;
        cfg_ch.data       = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Phase 0: reset settings (eight-bit, offset 64), nothing idles.
        // Directed: byte extremes, cursor corners, init, the awkward numbers, spare opcodes.
        send_request(OP_COMMAND, 8'h00, 1'b0, 6'd0,  32'd0);
        send_request(OP_COMMAND, 8'hff, 1'b1, 6'd63, 32'hffff_ffff);
        send_request(OP_DATA,    8'h00, 1'b0, 6'd0,  32'd0);
        send_request(OP_DATA,    8'hff, 1'b1, 6'd63, 32'hffff_ffff);
        send_request(OP_DATA,    8'ha5, 1'b0, 6'd21, 32'd0);
        send_request(OP_CURSOR,  8'h00, 1'b0, 6'd0,  32'd0);
        send_request(OP_CURSOR,  8'h00, 1'b0, 6'd63, 32'd0);
        send_request(OP_CURSOR,  8'h00, 1'b1, 6'd0,  32'd0);
        send_request(OP_CURSOR,  8'h00, 1'b1, 6'd63, 32'd0);
        send_request(OP_INIT,    8'h00, 1'b0, 6'd0,  32'd0);
        send_request(OP_PRINT,   8'h00, 1'b0, 6'd0,  32'd0);
        send_request(OP_PRINT,   8'h00, 1'b0, 6'd0,  32'd1);
        send_request(OP_PRINT,   8'h00, 1'b0, 6'd0,  32'hffff_ffff);
        send_request(OP_PRINT,   8'h00, 1'b0, 6'd0,  32'h7fff_ffff);
        send_request(OP_PRINT,   8'h00, 1'b0, 6'd0,  32'h8000_0000);
        send_request(OP_PRINT,   8'h00, 1'b0, 6'd0,  32'd1_000_000_000);
        send_request(OP_PRINT,   8'h00, 1'b0, 6'd0,  -32'sd10);
        send_request(OP_SPARE_LO, 8'h5a, 1'b1, 6'd7, 32'd5);
        send_request(OP_SPARE_LO + 3'd1, 8'h00, 1'b0, 6'd0, 32'd0);
        send_request(OP_SPARE_HI, 8'hff, 1'b1, 6'd63, 32'hffff_ffff);
        send_request(OP_DATA,    8'h5a, 1'b1, 6'd42, 32'd0);
        send_random(70);
        wait_idle();

        // Phase 1: nibble mode, widest row offset; the sender idles often.
        // Upper data bits of the mode word are random, only bit 0 should matter.
        write_register(CFG_FOUR_BIT, {(CFG_DAT_W-1)'($urandom), 1'b1});
        write_register(CFG_ROW_OFFSET, 7'd127);
        sender_idle_pct    = 54;
        receiver_stall_pct = 0;
        send_random(100);
        wait_idle();

        // Phase 2: back to eight data lines, zero offset; the receiver stalls often.
        write_register(CFG_FOUR_BIT, {(CFG_DAT_W-1)'($urandom), 1'b0});
        write_register(CFG_ROW_OFFSET, 7'd0);
        sender_idle_pct    = 0;
        receiver_stall_pct = 54;
        send_random(100);
        wait_idle();

        // Phase 3: nibble mode, random offset; light idling on both sides.
        write_register(CFG_FOUR_BIT, {(CFG_DAT_W-1)'($urandom), 1'b1});
        write_register(CFG_ROW_OFFSET, CFG_DAT_W'($urandom));
        sender_idle_pct    = 15;
        receiver_stall_pct = 15;
        send_random(100);
        wait_idle();

        // a last look for stray words after the final expected one
        receiver_stall_pct = 0;
        repeat (16) @(negedge clk);

        $display("Run covered %0d requests (%0d number prints, %0d spare opcodes), %0d strobe words,",
                 requests_sent, prints_sent, spares_sent, strobes_seen);
        $display("eight- and four-bit modes, row offsets 0/64/127/random, four idle and stall mixes.");
        if (fail_count == 0 && strobes_left == 0)
            $display("** char_lcd_write_sequencer_core: PASSED **");
        else
            $display("** char_lcd_write_sequencer_core: FAILED **");
        $finish;
    end

    // watchdog: well beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("** char_lcd_write_sequencer_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
